// ===== design/cfck_pkg.sv =====
package cfck_pkg;

  localparam int FRAME_DEPTH_DEF = 64;

  localparam logic [7:0] PREAMBLE       = 8'hFE;
  localparam logic [7:0] ACK_CODE       = 8'hFB;
  localparam logic [7:0] EOC            = 8'hFD;
  localparam logic [7:0] RADIO_ADDR_RST = 8'h80;
  localparam logic [7:0] CTRL_ADDR_RST  = 8'hE0;

  // func codes
  localparam logic FUNC_HOST = 1'b0;
  localparam logic FUNC_LINE = 1'b1;

  // config register indexes
  localparam logic CFG_RADIO_ADDR = 1'b0;
  localparam logic CFG_CTRL_ADDR  = 1'b1;

  // position inside the transmit sequence of one payload item
  localparam logic [2:0] POS_PRE0    = 3'd0;
  localparam logic [2:0] POS_PRE1    = 3'd1;
  localparam logic [2:0] POS_RADIO   = 3'd2;
  localparam logic [2:0] POS_CTRL    = 3'd3;
  localparam logic [2:0] POS_PAYLOAD = 3'd4;
  localparam logic [2:0] POS_EOC     = 3'd5;

  // acknowledge frame length and index of its FD
  localparam logic [2:0] ACK_LEN  = 3'd6;
  localparam logic [2:0] ACK_LAST = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_ECHO  = 2'd2,
    PH_REPLY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TX            = 2'd0,
    KIND_ECHO_VERDICT  = 2'd1,
    KIND_REPLY_BYTE    = 2'd2,
    KIND_REPLY_VERDICT = 2'd3
  } kind_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       payload_last;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       ok;
    logic       ovf;
    logic       last;
  } result_t;

  function automatic logic [7:0] ack_byte(input logic [2:0] idx,
                                          input logic [7:0] radio,
                                          input logic [7:0] ctrl);
    logic [7:0] b;
    case (idx)
      3'd0:    b = PREAMBLE;
      3'd1:    b = PREAMBLE;
      3'd2:    b = ctrl;
      3'd3:    b = radio;
      3'd4:    b = ACK_CODE;
      default: b = EOC;
    endcase
    return b;
  endfunction

endpackage

// ===== design/cfck_ram.sv =====
module cfck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/cfck_engine.sv =====
module cfck_engine import cfck_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  item_t      item,
  input  logic [7:0] radio_address,
  input  logic [7:0] controller_address,
  output logic       emit,
  output result_t    result,
  output logic       done
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);

  phase_t        phase, phase_next;
  logic [CW-1:0] sent_count, sent_count_next;
  logic [CW-1:0] echo_index, echo_index_next;
  logic          echo_match, echo_match_next;
  logic [2:0]    reply_index, reply_index_next;
  logic          reply_match, reply_match_next;
  logic          overflow_flag, overflow_flag_next;
  logic [2:0]    pos, pos_next;
  logic          started, started_next;

  logic [2:0]    eff_pos;
  logic [CW-1:0] sc;
  logic [7:0]    tx_byte;
  logic          ovf_new;
  logic          same;
  logic          wr_req;
  logic [CW-1:0] rd_index;
  logic [7:0]    rd_data;

  // read address follows the index the next step will use
  assign rd_index = step_en ? echo_index_next : echo_index;

  cfck_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_req & step_en),
    .wr_addr(sc[AW-1:0]),
    .wr_data(tx_byte),
    .rd_addr(rd_index[AW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    phase_next         = phase;
    sent_count_next    = sent_count;
    echo_index_next    = echo_index;
    echo_match_next    = echo_match;
    reply_index_next   = reply_index;
    reply_match_next   = reply_match;
    overflow_flag_next = overflow_flag;
    emit               = 1'b0;
    result             = '{kind: KIND_TX, data_byte: 8'h00, ok: 1'b0, ovf: 1'b0,
                           last: 1'b0};
    done               = 1'b0;
    wr_req             = 1'b0;
    sc                 = sent_count;
    tx_byte            = item.data_byte;
    ovf_new            = overflow_flag;
    same               = 1'b0;

    if (started) begin
      eff_pos = pos;
    end else if (item.func == FUNC_HOST && phase != PH_SEND) begin
      eff_pos = POS_PRE0;
    end else if (item.func == FUNC_HOST) begin
      eff_pos = POS_PAYLOAD;
    end else begin
      eff_pos = 3'd0;
    end

    if (item.func == FUNC_HOST) begin
      case (eff_pos)
        POS_PRE0:    tx_byte = PREAMBLE;
        POS_PRE1:    tx_byte = PREAMBLE;
        POS_RADIO:   tx_byte = radio_address;
        POS_CTRL:    tx_byte = controller_address;
        POS_PAYLOAD: tx_byte = item.data_byte;
        default:     tx_byte = EOC;
      endcase
      // opening a frame restarts the store
      sc      = (eff_pos == POS_PRE0) ? '0 : sent_count;
      ovf_new = (eff_pos == POS_PRE0) ? 1'b0 : overflow_flag;
      if (sc < DEPTH_C) begin
        wr_req          = 1'b1;
        sent_count_next = sc + CW'(1);
      end else begin
        sent_count_next = sc;
        ovf_new         = 1'b1;
      end
      overflow_flag_next = ovf_new;
      phase_next         = PH_SEND;
      emit               = 1'b1;
      result.kind        = KIND_TX;
      result.data_byte   = tx_byte;
      result.ovf         = ovf_new;
      if (eff_pos == POS_EOC) begin
        phase_next      = PH_ECHO;
        echo_index_next = '0;
        echo_match_next = 1'b1;
        done            = 1'b1;
      end else if (eff_pos == POS_PAYLOAD && !item.payload_last) begin
        done = 1'b1;
      end
      result.last = done;
    end else begin
      case (phase)
        PH_ECHO: begin
          same            = (echo_index < sent_count) && (rd_data == item.data_byte);
          echo_match_next = echo_match & same;
          done            = 1'b1;
          if (item.data_byte == EOC) begin
            emit        = 1'b1;
            result.kind = KIND_ECHO_VERDICT;
            result.ok   = echo_match_next & ~overflow_flag &
                          (echo_index + CW'(1) == sent_count);
            result.ovf  = overflow_flag;
            result.last = 1'b1;
            phase_next       = PH_REPLY;
            reply_index_next = '0;
            reply_match_next = 1'b1;
          end else if (echo_index < DEPTH_C) begin
            echo_index_next = echo_index + CW'(1);
          end
        end
        PH_REPLY: begin
          emit = 1'b1;
          if (eff_pos == 3'd0) begin
            same = (reply_index < ACK_LEN) &&
                   (ack_byte(reply_index, radio_address, controller_address)
                    == item.data_byte);
            reply_match_next = reply_match & same;
            result.kind      = KIND_REPLY_BYTE;
            result.data_byte = item.data_byte;
            if (item.data_byte != EOC) begin
              done        = 1'b1;
              result.last = 1'b1;
              if (reply_index < ACK_LEN) begin
                reply_index_next = reply_index + 3'd1;
              end
            end
          end else begin
            result.kind = KIND_REPLY_VERDICT;
            result.ok   = reply_match & (reply_index == ACK_LAST);
            result.last = 1'b1;
            phase_next  = PH_IDLE;
            done        = 1'b1;
          end
        end
        default: begin
          // line bytes outside an exchange are dropped
          done = 1'b1;
        end
      endcase
    end

    if (done) begin
      started_next = 1'b0;
      pos_next     = 3'd0;
    end else begin
      started_next = 1'b1;
      pos_next     = eff_pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      sent_count    <= '0;
      echo_index    <= '0;
      echo_match    <= 1'b1;
      reply_index   <= '0;
      reply_match   <= 1'b1;
      overflow_flag <= 1'b0;
      pos           <= '0;
      started       <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      sent_count    <= sent_count_next;
      echo_index    <= echo_index_next;
      echo_match    <= echo_match_next;
      reply_index   <= reply_index_next;
      reply_match   <= reply_match_next;
      overflow_flag <= overflow_flag_next;
      pos           <= pos_next;
      started       <= started_next;
    end
  end

  a_sent_count_range: assert property (@(posedge clk) disable iff (rst)
    sent_count <= DEPTH_C)
    else $error("sent_count beyond store depth");

  a_echo_index_range: assert property (@(posedge clk) disable iff (rst)
    echo_index <= DEPTH_C)
    else $error("echo_index beyond store depth");

  a_reply_index_range: assert property (@(posedge clk) disable iff (rst)
    reply_index <= ACK_LEN)
    else $error("reply_index beyond acknowledge length");

  a_verdict_ends_item: assert property (@(posedge clk) disable iff (rst)
    step_en && emit &&
    (result.kind == KIND_ECHO_VERDICT || result.kind == KIND_REPLY_VERDICT)
    |-> result.last && done)
    else $error("verdict not the last result of its item");

  a_pos_in_sequence: assert property (@(posedge clk) disable iff (rst)
    started |-> (pos != 3'd0) && (pos <= POS_EOC))
    else $error("sequence position out of range");

endmodule

// ===== design/radio_command_frame_checker_core.sv =====
// Command framer and echo/acknowledge checker for a transceiver serial bus.
// Item channel (item_valid/item_stall): func 0 carries a host payload byte,
// func 1 a byte received from the line; payload_last closes a command.
// Result channel (result_valid/result_stall): tx bytes, echo verdict, reply
// bytes and reply verdict; run_last marks the final result of one item.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the radio
// address, index 1 the controller address. Write only while idle.
// Flow: an item enters the input register, then one result per cycle, as
// long as no held result is stalled, is built into the output register. An
// opening payload byte yields the preamble, the addresses and the byte, plus
// the FD if it also closes the command; other payload bytes yield the byte and
// any closing FD. An echo byte yields nothing, its FD the echo verdict; a
// dropped line byte nothing; a reply byte itself, a reply FD also the reply
// verdict. The single output register is the limit. A new item is taken in
// the cycle its predecessor finishes its last step.
// Reset clears all control state; addresses return to 0x80 and 0xE0. The
// frame store needs no clearing. While a held result is stalled it stays
// and the item in work waits; item_stall rises once it cannot finish.
module radio_command_frame_checker_core import cfck_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic       payload_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       verdict_ok,
  output logic       overflow,
  output logic       run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  item_t      item_q;
  logic       item_full;
  result_t    res_q;
  logic       res_full;
  logic [7:0] radio_address;
  logic [7:0] controller_address;

  logic       fire;
  logic       emit;
  logic       done;
  result_t    step_res;
  logic       accept;

  assign fire       = item_full & (~res_full | ~result_stall);
  assign item_stall = item_full & ~(fire & done);
  assign accept     = item_valid & ~item_stall;
  assign cfg_ready  = 1'b1;

  cfck_engine #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .step_en           (fire),
    .item              (item_q),
    .radio_address     (radio_address),
    .controller_address(controller_address),
    .emit              (emit),
    .result            (step_res),
    .done              (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (accept) begin
      item_full <= 1'b1;
    end else if (fire && done) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= '{func: func, data_byte: data_byte, payload_last: payload_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (fire && emit) begin
      res_full <= 1'b1;
    end else if (!result_stall) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_q <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radio_address      <= RADIO_ADDR_RST;
      controller_address <= CTRL_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIO_ADDR: radio_address      <= cfg_data;
        CFG_CTRL_ADDR:  controller_address <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign result_valid = res_full;
  assign out_kind     = res_q.kind;
  assign out_byte     = res_q.data_byte;
  assign verdict_ok   = res_q.ok;
  assign overflow     = res_q.ovf;
  assign run_last     = res_q.last;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !item_full |-> !item_stall)
    else $error("input stalled with no item in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_full && result_stall |-> !fire)
    else $error("held result overwritten");

  a_item_leaves_on_done: assert property (@(posedge clk) disable iff (rst)
    item_full && fire && done && !item_valid |=> !item_full)
    else $error("finished item still held");

endmodule

// ===== bench/tb_radio_command_frame_checker_core.sv =====
`timescale 1ns / 100ps

module tb_radio_command_frame_checker_core;
  import cfck_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 250;
  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic       func;
  logic [7:0] data_byte;
  logic       payload_last;
  logic       result_valid;
  logic       result_stall;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       verdict_ok;
  logic       overflow;
  logic       run_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;

  radio_command_frame_checker_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .data_byte    (data_byte),
    .payload_last (payload_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .verdict_ok   (verdict_ok),
    .overflow     (overflow),
    .run_last     (run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // framer shadow state
  phase_t     fr_phase;
  logic [7:0] fr_store [FRAME_DEPTH_DEF];
  int         fr_sent;
  int         fr_echo_idx;
  logic       fr_echo_ok;
  int         fr_reply_idx;
  logic       fr_reply_ok;
  logic       fr_ovf;
  logic [7:0] radio_addr;
  logic [7:0] ctrl_addr;

  result_t step_out[$];
  result_t owed_results[$];

  int fail_count;
  int live_items;
  int cycle_count;
  int result_count;
  int tx_idle_max;
  int rx_idle_max;
  int rx_hold;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL radio_command_frame_checker_core");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 100)
      $display("mismatch %s: got %0h want %0h (result %0d, %0t)",
               what, got, want, result_count, $time);
    fail_count++;
  endtask

  function automatic void emit(kind_t k, logic [7:0] b, logic ok, logic ovf);
    result_t r;
    r.kind = k;
    r.data_byte = b;
    r.ok = ok;
    r.ovf = ovf;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void tx_byte(logic [7:0] b);
    if (fr_sent < FRAME_DEPTH_DEF) begin
      fr_store[fr_sent] = b;
      fr_sent++;
    end else begin
      fr_ovf = 1'b1;
    end
    emit(KIND_TX, b, 1'b0, fr_ovf);
  endfunction

  function automatic bytes_t build_ack();
    bytes_t a;
    a.push_back(PREAMBLE);
    a.push_back(PREAMBLE);
    a.push_back(ctrl_addr);
    a.push_back(radio_addr);
    a.push_back(ACK_CODE);
    a.push_back(EOC);
    return a;
  endfunction

  function automatic bytes_t frame_of(bytes_t p);
    bytes_t f;
    f.push_back(PREAMBLE);
    f.push_back(PREAMBLE);
    f.push_back(radio_addr);
    f.push_back(ctrl_addr);
    foreach (p[i]) f.push_back(p[i]);
    f.push_back(EOC);
    return f;
  endfunction

  // results one accepted item causes
  function automatic void frame_step(logic f, logic [7:0] b, logic l);
    logic   hit;
    logic   ok;
    bytes_t ack;
    step_out.delete();
    if (f == FUNC_HOST || fr_phase == PH_ECHO || fr_phase == PH_REPLY)
      live_items++;
    if (f == FUNC_HOST) begin
      if (fr_phase != PH_SEND) begin
        fr_sent = 0;
        fr_ovf = 1'b0;
        tx_byte(PREAMBLE);
        tx_byte(PREAMBLE);
        tx_byte(radio_addr);
        tx_byte(ctrl_addr);
        fr_phase = PH_SEND;
      end
      tx_byte(b);
      if (l) begin
        tx_byte(EOC);
        fr_phase = PH_ECHO;
        fr_echo_idx = 0;
        fr_echo_ok = 1'b1;
      end
    end else if (fr_phase == PH_ECHO) begin
      hit = (fr_echo_idx < fr_sent) && (fr_store[fr_echo_idx] == b);
      if (!hit) fr_echo_ok = 1'b0;
      if (b == EOC) begin
        ok = fr_echo_ok && !fr_ovf && (fr_echo_idx + 1 == fr_sent);
        emit(KIND_ECHO_VERDICT, 8'h00, ok, fr_ovf);
        fr_phase = PH_REPLY;
        fr_reply_idx = 0;
        fr_reply_ok = 1'b1;
      end else if (fr_echo_idx < FRAME_DEPTH_DEF) begin
        fr_echo_idx++;
      end
    end else if (fr_phase == PH_REPLY) begin
      ack = build_ack();
      hit = (fr_reply_idx < ACK_LEN) && (ack[fr_reply_idx] == b);
      if (!hit) fr_reply_ok = 1'b0;
      emit(KIND_REPLY_BYTE, b, 1'b0, 1'b0);
      if (b == EOC) begin
        emit(KIND_REPLY_VERDICT, 8'h00, fr_reply_ok && (fr_reply_idx == ACK_LAST), 1'b0);
        fr_phase = PH_IDLE;
      end else if (fr_reply_idx < ACK_LEN) begin
        fr_reply_idx++;
      end
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) owed_results.push_back(step_out[i]);
  endfunction

  // result side: random stall per result
  initial begin
    result_stall = 1'b0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        result_stall = 1'b1;
        rx_hold--;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      result_count++;
      rx_hold = $urandom_range(0, rx_idle_max);
      if (owed_results.size() == 0) begin
        report_mismatch("result with none owed", out_kind, 0);
      end else begin
        want = owed_results.pop_front();
        if (out_kind !== want.kind) report_mismatch("out_kind", out_kind, want.kind);
        if (out_byte !== want.data_byte)
          report_mismatch("out_byte", out_byte, want.data_byte);
        if (verdict_ok !== want.ok) report_mismatch("verdict_ok", verdict_ok, want.ok);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
        if (run_last !== want.last) report_mismatch("run_last", run_last, want.last);
      end
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b, input logic l);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    func = f;
    data_byte = b;
    payload_last = l;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    frame_step(f, b, l);
  endtask

  task automatic send_host(input bytes_t p, input bit noisy);
    foreach (p[i]) begin
      // line bytes while a frame is assembled must be dropped
      if (noisy && i > 0 && $urandom_range(0, 3) == 0)
        send_item(FUNC_LINE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(FUNC_HOST, p[i], i == p.size() - 1);
    end
  endtask

  task automatic send_line(input bytes_t q);
    foreach (q[i]) send_item(FUNC_LINE, q[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic settle_idle();
    @(negedge clk);
    item_valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_RADIO_ADDR) radio_addr = val;
    else ctrl_addr = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic exchange(input bytes_t p);
    bytes_t fr;
    fr = frame_of(p);
    send_host(p, 1'b0);
    send_line(fr);
    send_line(build_ack());
  endtask

  // runs first so that every store entry is written before any long echo
  task automatic test_overflow_frame();
    bytes_t p;
    bytes_t q;
    for (int i = 0; i < 61; i++) p.push_back(8'($urandom_range(0, 255)));
    p[0] = 8'h00;
    p[1] = 8'hFF;
    send_host(p, 1'b0);
    q.push_back(EOC);
    send_line(q);
    send_line(build_ack());
    settle_idle();
  endtask

  task automatic test_clean_exchange();
    bytes_t p;
    p.push_back(8'h00);
    p.push_back(8'hFF);
    exchange(p);
    settle_idle();
  endtask

  task automatic test_payload_eoc();
    bytes_t p;
    p.push_back(EOC);
    p.push_back(8'h55);
    send_host(p, 1'b0);
    // echo stops at the embedded FD; the tail lands in the reply
    send_line(frame_of(p));
    settle_idle();
  endtask

  task automatic test_bad_echo_and_reply();
    bytes_t p;
    bytes_t e;
    bytes_t a;
    p.push_back(8'hA5);
    e = frame_of(p);
    e[4] = 8'h5A;
    send_host(p, 1'b0);
    send_line(e);
    a = build_ack();
    a.insert(5, 8'h00);
    a.insert(5, 8'h01);
    send_line(a);
    // echo longer than the frame
    send_host(p, 1'b0);
    e = frame_of(p);
    e.insert(5, 8'h33);
    send_line(e);
    a = build_ack();
    a[4] = 8'hFA;
    send_line(a);
    settle_idle();
  endtask

  task automatic test_dropped_and_abandoned();
    bytes_t p;
    bytes_t e;
    e.push_back(8'h12);
    e.push_back(EOC);
    send_line(e);
    send_item(FUNC_HOST, 8'h3C, 1'b0);
    send_item(FUNC_LINE, PREAMBLE, 1'b1);
    send_item(FUNC_HOST, 8'hC3, 1'b1);
    // new payload while the echo is pending
    send_item(FUNC_LINE, PREAMBLE, 1'b0);
    p.push_back(8'h81);
    send_host(p, 1'b0);
    e = frame_of(p);
    send_line(e);
    // new payload while the reply is pending
    send_item(FUNC_LINE, PREAMBLE, 1'b0);
    exchange(p);
    settle_idle();
  endtask

  task automatic test_address_regs();
    bytes_t p;
    p.push_back(8'h7E);
    write_reg(CFG_RADIO_ADDR, 8'h00);
    write_reg(CFG_CTRL_ADDR, 8'hFF);
    exchange(p);
    settle_idle();
    write_reg(CFG_RADIO_ADDR, 8'hFF);
    write_reg(CFG_CTRL_ADDR, 8'h00);
    exchange(p);
    settle_idle();
  endtask

  task automatic test_random_traffic();
    int     stop_at;
    int     iter;
    int     len;
    int     k;
    bytes_t p;
    bytes_t e;
    bytes_t a;
    stop_at = live_items + RANDOM_ITEMS;
    iter = 0;
    while (live_items < stop_at) begin
      if ((iter / 6) % 4 == 2) begin
        tx_idle_max = 0;
        rx_idle_max = 0;
      end else begin
        tx_idle_max = 11;
        rx_idle_max = 11;
      end
      if (iter % 9 == 8) begin
        settle_idle();
        k = $urandom_range(0, 3);
        write_reg(CFG_RADIO_ADDR, k == 0 ? 8'h00 : k == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
        k = $urandom_range(0, 3);
        write_reg(CFG_CTRL_ADDR, k == 0 ? 8'h00 : k == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 8) begin
        e.delete();
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) e.push_back(8'($urandom_range(0, 255)));
        send_line(e);
      end else begin
        p.delete();
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(55, 66) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          p.push_back($urandom_range(0, 15) == 0 ? EOC : 8'($urandom_range(0, 255)));
        e = frame_of(p);
        send_host(p, $urandom_range(0, 9) == 0);
        k = $urandom_range(0, 99);
        if (k < 70) begin
        end else if (k < 78) begin
          e[$urandom_range(0, e.size() - 2)] ^= 8'h01 << $urandom_range(0, 7);
        end else if (k < 85) begin
          e.delete($urandom_range(0, e.size() - 2));
        end else if (k < 92) begin
          e.insert($urandom_range(0, e.size() - 1), 8'($urandom_range(0, 255)));
        end else begin
          e.delete();
        end
        if (e.size() > 0) begin
          send_line(e);
          a = build_ack();
          k = $urandom_range(0, 99);
          if (k < 70) begin
          end else if (k < 82) begin
            a[$urandom_range(0, a.size() - 1)] ^= 8'h01 << $urandom_range(0, 7);
          end else if (k < 92) begin
            a.delete();
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) a.push_back(8'($urandom_range(0, 255)));
            a.push_back(EOC);
          end else begin
            a.delete();
          end
          send_line(a);
        end
      end
      iter++;
    end
    tx_idle_max = 11;
    rx_idle_max = 11;
    settle_idle();
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    func = FUNC_HOST;
    data_byte = 8'h00;
    payload_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIO_ADDR;
    cfg_data = 8'h00;
    fail_count = 0;
    live_items = 0;
    cycle_count = 0;
    result_count = 0;
    tx_idle_max = 11;
    rx_idle_max = 11;
    fr_phase = PH_IDLE;
    fr_sent = 0;
    fr_echo_idx = 0;
    fr_echo_ok = 1'b1;
    fr_reply_idx = 0;
    fr_reply_ok = 1'b1;
    fr_ovf = 1'b0;
    radio_addr = RADIO_ADDR_RST;
    ctrl_addr = CTRL_ADDR_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_overflow_frame();
    test_clean_exchange();
    test_payload_eoc();
    test_bad_echo_and_reply();
    test_dropped_and_abandoned();
    test_address_regs();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("PASS radio_command_frame_checker_core");
    end else begin
      $display("FAIL radio_command_frame_checker_core");
    end
    $finish;
  end

endmodule
